[rtl/core/eih_pkg.sv]
// Package for the equal-interval histogram engine.
// Holds the sizes, input, status and register codes, FSM states and the divider result type.
// No dependencies.
`default_nettype none

package eih_pkg;

  localparam int MAX_BINS   = 256;
  localparam int BIN_BITS   = $clog2(MAX_BINS);
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 32;
  localparam int NCNT_BITS  = BIN_BITS + 1;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_NULL   = 2'd1;
  localparam logic [1:0] MODE_RDBIN  = 2'd2;
  localparam logic [1:0] MODE_RDNULL = 2'd3;

  localparam logic [1:0] STAT_COUNTED = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_READ    = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  localparam logic [1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd2;
  localparam logic [1:0] REG_BIN_COUNT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic                done;
    logic [BIN_BITS-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

[rtl/core/equal_interval_histogram.sv]
// Equal-interval histogram engine: bin counters in a one-port-read synchronous RAM.
// Depends on eih_pkg and eih_div.
//
// Channel   Direction  Handshake              Payload
// input     in         start & !busy          in_mode, in_sample_value, in_read_bin
// result    out        out_valid (one cycle)  out_hit_bin, out_count_value, out_status
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// Null samples, null reads and dropped samples: result in the cycle after accept,
// busy stays low, one item per cycle. Bin reads and single-bin samples: RAM read,
// then update. Binned samples: the 8-step divider, then the RAM read and write-back.
// One item is in flight at a time, so a read never overlaps the write-back of the
// same bin. Reset clears all counters at once through per-bin valid bits. The
// receiver cannot stall.
`default_nettype none

module equal_interval_histogram
  import eih_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_mode,
  input  wire logic [VALUE_BITS-1:0] in_sample_value,
  input  wire logic [BIN_BITS-1:0]   in_read_bin,
  output logic                       out_valid,
  output logic [BIN_BITS-1:0]        out_hit_bin,
  output logic [COUNT_BITS-1:0]      out_count_value,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [VALUE_BITS-1:0] cfg_wdata
);

  state_t                state_r, state_nxt;

  logic [VALUE_BITS-1:0] range_min_r;
  logic [VALUE_BITS-1:0] range_max_r;
  logic [VALUE_BITS-1:0] bin_width_r;
  logic [NCNT_BITS-1:0]  nbins_r;
  logic [NCNT_BITS-1:0]  nbins_wr;

  logic [COUNT_BITS-1:0] null_r, null_nxt;
  logic [BIN_BITS-1:0]   addr_r, addr_nxt;
  logic                  op_rd_r, op_rd_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [BIN_BITS-1:0]   out_hit_r, out_hit_nxt;
  logic [COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic [1:0]            out_stat_r, out_stat_nxt;

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_en;
  logic [BIN_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cur_inc;

  logic                  accept;
  logic                  out_of_range;
  logic [VALUE_BITS-1:0] offset;
  logic [VALUE_BITS-1:0] width_eff;
  logic [NCNT_BITS-1:0]  last_bin;
  logic [BIN_BITS-1:0]   k_clamped;
  logic                  div_go;
  div_res_t              div_res;

  assign accept       = start && !busy;
  assign busy         = (state_r != ST_IDLE);
  assign out_of_range = ($signed(in_sample_value) < $signed(range_min_r)) ||
                        ($signed(in_sample_value) > $signed(range_max_r));
  assign offset       = in_sample_value - range_min_r;
  assign width_eff    = (bin_width_r == '0) ? VALUE_BITS'(1) : bin_width_r;
  assign last_bin     = nbins_r - 1'b1;
  assign k_clamped    = ({1'b0, div_res.quot} > last_bin) ? last_bin[BIN_BITS-1:0]
                                                          : div_res.quot;
  assign cur          = rd_vld_r ? rd_data_r : '0;
  assign cur_inc      = cur + 1'b1;

  // clamp the bin count at write time from the low 16 bits: zero acts as one, above MAX_BINS as MAX_BINS
  always_comb begin
    if (cfg_wdata[15:0] == '0) begin
      nbins_wr = NCNT_BITS'(1);
    end else if (cfg_wdata[15:0] > 16'(MAX_BINS)) begin
      nbins_wr = NCNT_BITS'(MAX_BINS);
    end else begin
      nbins_wr = cfg_wdata[NCNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= '0;
      range_max_r <= VALUE_BITS'(1310720);
      bin_width_r <= VALUE_BITS'(65536);
      nbins_r     <= NCNT_BITS'(20);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_MIN: range_min_r <= cfg_wdata;
        REG_RANGE_MAX: range_max_r <= cfg_wdata;
        REG_BIN_WIDTH: bin_width_r <= cfg_wdata;
        REG_BIN_COUNT: nbins_r     <= nbins_wr;
        default: ;
      endcase
    end
  end

  eih_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (offset),
    .divisor  (width_eff),
    .res      (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    null_nxt      = null_r;
    addr_nxt      = addr_r;
    op_rd_nxt     = op_rd_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    div_go        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_SAMPLE: begin
              if (nbins_r == NCNT_BITS'(1)) begin
                rd_en     = 1'b1;
                op_rd_nxt = 1'b0;
                state_nxt = ST_UPD;
              end else if (out_of_range) begin
                out_valid_nxt = 1'b1;
                out_hit_nxt   = '0;
                out_cnt_nxt   = '0;
                out_stat_nxt  = STAT_DROPPED;
              end else begin
                div_go    = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            MODE_NULL: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = '0;
              if (&null_r) begin
                out_cnt_nxt  = null_r;
                out_stat_nxt = STAT_SAT;
              end else begin
                null_nxt     = null_r + 1'b1;
                out_cnt_nxt  = null_r + 1'b1;
                out_stat_nxt = STAT_COUNTED;
              end
            end
            MODE_RDBIN: begin
              rd_en     = 1'b1;
              rd_addr   = in_read_bin;
              op_rd_nxt = 1'b1;
              state_nxt = ST_UPD;
            end
            MODE_RDNULL: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = '0;
              out_cnt_nxt   = null_r;
              out_stat_nxt  = STAT_READ;
            end
            default: ;
          endcase
          addr_nxt = rd_addr;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          rd_en     = 1'b1;
          rd_addr   = k_clamped;
          addr_nxt  = k_clamped;
          op_rd_nxt = 1'b0;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = addr_r;
        if (op_rd_r) begin
          out_cnt_nxt  = cur;
          out_stat_nxt = STAT_READ;
        end else if (&cur) begin
          out_cnt_nxt  = cur;
          out_stat_nxt = STAT_SAT;
        end else begin
          wr_en        = 1'b1;
          out_cnt_nxt  = cur_inc;
          out_stat_nxt = STAT_COUNTED;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      null_r      <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      null_r      <= null_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    op_rd_r    <= op_rd_nxt;
    out_hit_r  <= out_hit_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= cur_inc;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit_bin     = out_hit_r;
  assign out_count_value = out_cnt_r;
  assign out_status      = out_stat_r;

  a_upd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> out_valid)
    else $error("update cycle produced no item");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_null_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_RDNULL)) |=> (out_valid && (out_status == STAT_READ)
      && (out_count_value == $past(null_r))))
    else $error("null count read returned a wrong item");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_SAT)) |-> (&out_count_value))
    else $error("saturated status with a counter below its maximum");

endmodule

`default_nettype wire

[rtl/core/eih_div.sv]
// Bin index divider: offset / bin width, one quotient bit per cycle.
// Quotient saturates at all ones when the offset spans the whole index range.
// Depends on eih_pkg.
`default_nettype none

module eih_div
  import eih_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output div_res_t                   res
);

  localparam int WIDE_BITS = VALUE_BITS + BIN_BITS;

  logic                  busy_r;
  logic                  done_r;
  logic                  ovf_r;
  logic [BIN_BITS-1:0]   q_r;
  logic [$clog2(BIN_BITS)-1:0] step_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] dvs_r;
  logic [WIDE_BITS-1:0]  wsh;
  logic                  fits;

  assign wsh  = {{BIN_BITS{1'b0}}, dvs_r} << step_r;
  assign fits = {{BIN_BITS{1'b0}}, rem_r} >= wsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r  <= dividend;
      dvs_r  <= divisor;
      ovf_r  <= {{BIN_BITS{1'b0}}, dividend} >= {divisor, {BIN_BITS{1'b0}}};
      q_r    <= '0;
      step_r <= '1;
    end else if (busy_r) begin
      if (fits) begin
        rem_r     <= rem_r - wsh[VALUE_BITS-1:0];
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
  end

  assign res.done = done_r;
  assign res.quot = ovf_r ? '1 : q_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the equal-interval histogram engine.
// Streams sample, null and read items under many bin settings; checks every result.
// Depends on eih_pkg and equal_interval_histogram.
`timescale 1ns / 100ps

module testbench;
  import eih_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 90;

  typedef struct {
    logic [1:0]            mode;
    logic [VALUE_BITS-1:0] sample;
    logic [BIN_BITS-1:0]   rbin;
  } hist_req_t;

  typedef struct {
    logic [BIN_BITS-1:0]   hit;
    logic [COUNT_BITS-1:0] count;
    logic [1:0]            status;
  } hist_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [1:0]            in_mode = MODE_SAMPLE;
  logic [VALUE_BITS-1:0] in_sample_value = '0;
  logic [BIN_BITS-1:0]   in_read_bin = '0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_RANGE_MIN;
  logic [VALUE_BITS-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_valid;
  logic [BIN_BITS-1:0]   out_hit_bin;
  logic [COUNT_BITS-1:0] out_count_value;
  logic [1:0]            out_status;

  // bin settings as the block holds them
  logic signed [VALUE_BITS-1:0] lo_edge = 32'sd0;
  logic signed [VALUE_BITS-1:0] hi_edge = 32'sd1310720;
  logic [VALUE_BITS-1:0]        step_width = 32'd65536;
  logic [15:0]                  bins_reg = 16'd20;

  logic [COUNT_BITS-1:0] bin_tally [MAX_BINS];
  logic [COUNT_BITS-1:0] null_tally;

  hist_req_t sample_feed [$];
  hist_res_t awaited_tallies [$];
  hist_req_t next_req;
  hist_req_t seen_req;
  hist_res_t want;

  logic took = 1'b0;
  int   idle_pct = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   accepted = 0;
  int   by_status [4] = '{0, 0, 0, 0};

  equal_interval_histogram DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_sample_value (in_sample_value),
    .in_read_bin     (in_read_bin),
    .out_valid       (out_valid),
    .out_hit_bin     (out_hit_bin),
    .out_count_value (out_count_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int bins_in_effect();
    if (bins_reg == 0) return 1;
    if (bins_reg > MAX_BINS) return MAX_BINS;
    return int'(bins_reg);
  endfunction

  function automatic hist_res_t tally_item(hist_req_t r);
    hist_res_t res;
    longint unsigned offs;
    longint unsigned w;
    longint unsigned k;
    int n;
    res.hit = '0;
    res.count = '0;
    res.status = STAT_COUNTED;
    n = bins_in_effect();
    case (r.mode)
      MODE_SAMPLE: begin
        if (n > 1 && ($signed(r.sample) < lo_edge || $signed(r.sample) > hi_edge)) begin
          res.status = STAT_DROPPED;
        end else begin
          k = 0;
          if (n > 1) begin
            offs = longint'($signed(r.sample)) - longint'(lo_edge);
            w = (step_width == 0) ? 64'd1 : 64'(step_width);
            k = offs / w;
            if (k > n - 1) k = 64'(n - 1);
          end
          if (bin_tally[k] == '1) res.status = STAT_SAT;
          else bin_tally[k] = bin_tally[k] + 1;
          res.hit = k[BIN_BITS-1:0];
          res.count = bin_tally[k];
        end
      end
      MODE_NULL: begin
        if (null_tally == '1) res.status = STAT_SAT;
        else null_tally = null_tally + 1;
        res.count = null_tally;
      end
      MODE_RDBIN: begin
        res.hit = r.rbin;
        res.count = bin_tally[r.rbin];
        res.status = STAT_READ;
      end
      default: begin
        res.count = null_tally;
        res.status = STAT_READ;
      end
    endcase
    return res;
  endfunction

  function automatic hist_req_t make_item();
    hist_req_t r;
    int pick;
    int n;
    longint span;
    longint v;
    longint unsigned rnd;
    n = bins_in_effect();
    pick = $urandom_range(0, 99);
    if (pick < 60) r.mode = MODE_SAMPLE;
    else if (pick < 70) r.mode = MODE_NULL;
    else if (pick < 90) r.mode = MODE_RDBIN;
    else r.mode = MODE_RDNULL;
    r.sample = $urandom;
    r.rbin = BIN_BITS'($urandom_range(0, 255));
    if (r.mode == MODE_RDBIN && $urandom_range(0, 9) < 7) begin
      r.rbin = BIN_BITS'($urandom_range(0, n - 1));
    end
    if (r.mode == MODE_SAMPLE) begin
      span = longint'(hi_edge) - longint'(lo_edge);
      pick = $urandom_range(0, 99);
      if (span >= 0 && pick < 65) begin
        rnd = {$urandom, $urandom};
        v = longint'(lo_edge) + longint'(rnd % longint'(span + 1));
        r.sample = v[VALUE_BITS-1:0];
      end else if (pick < 80) begin
        v = longint'(lo_edge) + longint'($urandom_range(0, n)) * longint'(step_width)
            + longint'($urandom_range(0, 2)) - 1;
        r.sample = v[VALUE_BITS-1:0];
      end else if (pick < 88) begin
        v = longint'(hi_edge) + longint'($urandom_range(0, 2)) - 1;
        r.sample = v[VALUE_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic push_req(logic [1:0] mode, logic [VALUE_BITS-1:0] sample,
                          logic [BIN_BITS-1:0] rbin);
    hist_req_t r;
    r.mode = mode;
    r.sample = sample;
    r.rbin = rbin;
    sample_feed.push_back(r);
  endtask

  task automatic feed_random(int pct);
    idle_pct = pct;
    repeat (RANDOM_ITEMS) sample_feed.push_back(make_item());
  endtask

  task automatic wait_drained();
    while (sample_feed.size() != 0 || start || awaited_tallies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [VALUE_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_bins(logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
                          logic [VALUE_BITS-1:0] w, logic [VALUE_BITS-1:0] cnt);
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    write_reg(REG_BIN_WIDTH, w);
    write_reg(REG_BIN_COUNT, cnt);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: present the next item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (sample_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_req = sample_feed.pop_front();
        start <= 1'b1;
        in_mode <= next_req.mode;
        in_sample_value <= next_req.sample;
        in_read_bin <= next_req.rbin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: track settings, check results, predict each accepted item
  always @(posedge clk) begin
    took <= start && !busy;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN: lo_edge = cfg_wdata;
        REG_RANGE_MAX: hi_edge = cfg_wdata;
        REG_BIN_WIDTH: step_width = cfg_wdata;
        REG_BIN_COUNT: bins_reg = cfg_wdata[15:0];
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      if (awaited_tallies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit_bin %0d count %0d status %0d",
                 $time, out_hit_bin, out_count_value, out_status);
      end else begin
        want = awaited_tallies.pop_front();
        by_status[want.status]++;
        if (out_hit_bin !== want.hit) begin
          errors++;
          $display("%0t: hit_bin expected %0d got %0d", $time, want.hit, out_hit_bin);
        end
        if (out_count_value !== want.count) begin
          errors++;
          $display("%0t: count_value expected %0d got %0d", $time, want.count,
                   out_count_value);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
      end
    end
    if (rst_n && start && !busy) begin
      seen_req.mode = in_mode;
      seen_req.sample = in_sample_value;
      seen_req.rbin = in_read_bin;
      awaited_tallies.push_back(tally_item(seen_req));
      accepted++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_tallies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] rlo;
    longint rhi;
    for (int i = 0; i < MAX_BINS; i++) bin_tally[i] = '0;
    null_tally = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default settings: 20 bins of 1.0 over [0, 20.0]
    idle_pct = 18;
    push_req(MODE_SAMPLE, 32'h0000_0000, 8'd0);
    push_req(MODE_SAMPLE, 32'h0001_0000, 8'd255);
    push_req(MODE_SAMPLE, 32'h0000_FFFF, 8'd0);
    push_req(MODE_SAMPLE, 32'h0014_0000, 8'd0);
    push_req(MODE_SAMPLE, 32'h0014_0001, 8'd0);
    push_req(MODE_SAMPLE, 32'hFFFF_FFFF, 8'd0);
    push_req(MODE_SAMPLE, 32'h8000_0000, 8'd0);
    push_req(MODE_SAMPLE, 32'h7FFF_FFFF, 8'd0);
    push_req(MODE_SAMPLE, 32'h0013_0000, 8'd0);
    push_req(MODE_SAMPLE, 32'h000A_8000, 8'd0);
    push_req(MODE_NULL, 32'hFFFF_FFFF, 8'd255);
    push_req(MODE_NULL, 32'h0000_0000, 8'd0);
    push_req(MODE_RDNULL, 32'h8000_0000, 8'd255);
    push_req(MODE_RDBIN, 32'h0000_0000, 8'd0);
    push_req(MODE_RDBIN, 32'h0000_0000, 8'd19);
    push_req(MODE_RDBIN, 32'hFFFF_FFFF, 8'd255);
    push_req(MODE_RDBIN, 32'h0000_0000, 8'd20);
    push_req(MODE_SAMPLE, 32'h0000_0000, 8'd255);
    push_req(MODE_RDBIN, 32'h0000_0000, 8'd1);
    wait_drained();
    feed_random(18);
    wait_drained();

    // full signed span, widest bins
    set_bins(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd256);
    feed_random(18);
    wait_drained();

    set_bins(32'hFFF6_0000, 32'h000A_0000, 32'h0000_8000, 32'd40);
    feed_random(18);
    wait_drained();

    // one bin takes everything
    set_bins(32'h0001_0000, 32'h0005_0000, 32'h0001_0000, 32'd1);
    feed_random(61);
    wait_drained();

    // inverted range drops every sample
    set_bins(32'h0005_0000, 32'hFFFB_0000, 32'h0001_0000, 32'd8);
    feed_random(61);
    wait_drained();

    // zero width acts as one step, count above the maximum is clamped
    set_bins(32'hFFFF_FF9C, 32'd1000, 32'd0, 32'd511);
    feed_random(61);
    wait_drained();

    // zero count acts as one bin
    set_bins(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'd0);
    feed_random(0);
    wait_drained();

    set_bins(32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0000, 32'd300);
    feed_random(0);
    wait_drained();

    // zero-length range
    set_bins(32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 32'd5);
    feed_random(0);
    wait_drained();

    rlo = $urandom;
    rhi = longint'($signed(rlo)) + longint'($urandom_range(0, 32'h00FF_FFFF));
    if (rhi > 64'sd2147483647) rhi = 64'sd2147483647;
    set_bins(rlo, rhi[VALUE_BITS-1:0], $urandom_range(1, 32'h0010_0000),
             $urandom_range(2, MAX_BINS));
    feed_random(0);
    wait_drained();

    $display("Ran %0d items over 10 bin settings: %0d counted, %0d dropped,",
             accepted, by_status[STAT_COUNTED], by_status[STAT_DROPPED]);
    $display("  %0d reads, %0d saturated", by_status[STAT_READ], by_status[STAT_SAT]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
